FILE: rtl/order_risk_gate_with_positions_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the order risk gate
// checks compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ORDER_RISK_GATE_WITH_POSITIONS_MACROS_SVH
`define ORDER_RISK_GATE_WITH_POSITIONS_MACROS_SVH
`ifndef SYNTH
`define ORG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ORG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ORG_ASSERT(lbl, clk, rst, prop, msg)
`define ORG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/org_pkg.sv
// ----------------------------------------------------------------------------
// org_pkg
// types, codes and helper functions shared by the order risk gate
// ----------------------------------------------------------------------------
package org_pkg;

  localparam int CFG_W    = 62;
  localparam int IN_DW    = 80;
  localparam int OUT_DW   = 72;

  localparam logic [1:0] CFG_MAX_ORDER_VALUE    = 2'd0;
  localparam logic [1:0] CFG_MAX_ORDER_QUANTITY = 2'd1;
  localparam logic [1:0] CFG_MAX_POSITION_VALUE = 2'd2;

  localparam logic ACT_ORDER = 1'b0;
  localparam logic ACT_FILL  = 1'b1;

  localparam logic [2:0] REASON_NONE     = 3'd0;
  localparam logic [2:0] REASON_BAD      = 3'd1;
  localparam logic [2:0] REASON_VALUE    = 3'd2;
  localparam logic [2:0] REASON_QUANTITY = 3'd3;
  localparam logic [2:0] REASON_POSITION = 3'd4;

  localparam logic [5:0] DIV_LAST_STEP = 6'd63;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_EVAL,
    ST_DIV,
    ST_FIN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rd;
    logic load_pos;
    logic mul1;
    logic mul2;
    logic eval;
    logic div_step;
    logic fin;
    logic wr;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_wr;
    logic div_last;
    logic clr_last;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (!v[32] && v[31]) begin
      sat33 = 32'sh7FFF_FFFF;
    end else if (v[32] && !v[31]) begin
      sat33 = 32'sh8000_0000;
    end else begin
      sat33 = v[31:0];
    end
  endfunction

endpackage

FILE: rtl/org_ram.sv
// ----------------------------------------------------------------------------
// org_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module org_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/org_ctrl.sv
// ----------------------------------------------------------------------------
// org_ctrl
// sequencer for table clearing, order checks and fill updates
// ----------------------------------------------------------------------------
`include "order_risk_gate_with_positions_macros.svh"
module org_ctrl
  import org_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   s_fire;

  assign s_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_pos = 1'b1;
        state_next   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.need_div) begin
          state_next = ST_DIV;
        end else if (sts.need_wr) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ORG_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> (state == ST_CLEAR), "reset must start clearing")
  `ORG_ASSERT(a_accept_reads, clk, rst, s_fire |=> (state == ST_READ), "accepted item must read the table")
  `ORG_ASSERT(a_div_only_needed, clk, rst, (state == ST_EVAL && !sts.need_div) |=> (state != ST_DIV), "divider started without need")
  `ORG_ASSERT(a_out_free, clk, rst, cmd.out_load |-> sts.out_free, "result loaded over a pending transfer")

endmodule

FILE: rtl/org_dpath.sv
// ----------------------------------------------------------------------------
// org_dpath
// position table, shared multiplier, serial divider and result register
// ----------------------------------------------------------------------------
module org_dpath
  import org_pkg::*;
#(
  parameter int CLIENT_SLOTS     = 16,
  parameter int INSTRUMENT_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [IN_DW-1:0]  s_tdata,
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,
  output logic              m_tuser,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int DEPTH = CLIENT_SLOTS * INSTRUMENT_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [61:0] max_ov;
  logic [30:0] max_oq;
  logic [61:0] max_pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ov <= '0;
      max_oq <= '0;
      max_pv <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ORDER_VALUE:    max_ov <= cfg_data[61:0];
        CFG_MAX_ORDER_QUANTITY: max_oq <= cfg_data[30:0];
        CFG_MAX_POSITION_VALUE: max_pv <= cfg_data[61:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic               act;
  logic signed [31:0] qty;
  logic signed [31:0] price;
  logic [AW-1:0]      addr;
  logic               slot_ok;
  logic [3:0]         in_cs;
  logic [5:0]         in_is;
  logic [31:0]        addr_full;

  assign in_cs     = s_tdata[3:0];
  assign in_is     = s_tdata[9:4];
  assign addr_full = 32'(in_cs) * 32'(INSTRUMENT_SLOTS) + 32'(in_is);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act     <= s_tuser;
      qty     <= s_tdata[41:10];
      price   <= s_tdata[73:42];
      addr    <= addr_full[AW-1:0];
      slot_ok <= (32'(in_cs) < 32'(CLIENT_SLOTS)) && (32'(in_is) < 32'(INSTRUMENT_SLOTS));
    end
  end

  // position table, average in the upper half
  logic [AW-1:0] clr_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;

  logic               res_acc;
  logic [2:0]         res_reason;
  logic signed [31:0] res_q;
  logic signed [31:0] res_a;

  assign ram_we    = cmd.clr_wr || cmd.wr;
  assign ram_waddr = cmd.clr_wr ? clr_addr : addr;
  assign ram_wdata = cmd.clr_wr ? 64'd0 : {res_a, res_q};

  org_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // held position, out of range slots read as flat
  logic signed [31:0] held;
  logic signed [31:0] avg;
  logic signed [32:0] nq;
  logic signed [31:0] held_c;

  assign held_c = slot_ok ? ram_rdata[31:0] : 32'sd0;

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      held <= held_c;
      avg  <= slot_ok ? ram_rdata[63:32] : 32'sd0;
      nq   <= 33'(held_c) + 33'(qty);
    end
  end

  // shared multiplier on magnitudes
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  logic [63:0] prod1;
  logic [63:0] prod2;
  logic        sgn1;
  logic        sgn2;

  always_comb begin
    if (cmd.mul1) begin
      mul_a = {1'b0, mag32(qty)};
      mul_b = mag32(price);
    end else begin
      mul_a = (act == ACT_FILL) ? {1'b0, mag32(held)} : mag33(nq);
      mul_b = mag32(avg);
    end
  end

  assign mul_p = 65'(mul_a) * 65'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1 <= mul_p[63:0];
      sgn1  <= qty[31] ^ price[31];
    end
    if (cmd.mul2) begin
      prod2 <= mul_p[63:0];
      sgn2  <= held[31] ^ avg[31];
    end
  end

  // order tests
  logic       bad;
  logic       over_val;
  logic       over_qty;
  logic       over_pos;
  logic [2:0] reason_c;

  assign bad      = (price <= 32'sd0) || (qty <= 32'sd0);
  assign over_val = prod1 > {2'b00, max_ov};
  assign over_qty = qty[30:0] > max_oq;
  assign over_pos = prod2 > {2'b00, max_pv};

  always_comb begin
    if (bad) begin
      reason_c = REASON_BAD;
    end else if (over_val) begin
      reason_c = REASON_VALUE;
    end else if (over_qty) begin
      reason_c = REASON_QUANTITY;
    end else if (over_pos) begin
      reason_c = REASON_POSITION;
    end else begin
      reason_c = REASON_NONE;
    end
  end

  // signed sum of the two products as sign and magnitude
  logic [63:0] tm_c;
  logic        tn_c;

  always_comb begin
    if (sgn1 == sgn2) begin
      tm_c = prod2 + prod1;
      tn_c = sgn2;
    end else if (prod2 >= prod1) begin
      tm_c = prod2 - prod1;
      tn_c = sgn2;
    end else begin
      tm_c = prod1 - prod2;
      tn_c = sgn1;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic        tn;
  logic [33:0] rem;
  logic [63:0] dq;
  logic [5:0]  cnt;
  logic [32:0] dvs;
  logic [33:0] trial;
  logic        ge;

  assign dvs   = mag33(nq);
  assign trial = {rem[32:0], dq[63]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      tn  <= tn_c;
      dq  <= tm_c;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? (trial - {1'b0, dvs}) : trial;
      dq  <= {dq[62:0], ge};
      cnt <= cnt + 6'd1;
    end
  end

  // saturated quotient
  logic               q_big;
  logic               q_neg;
  logic signed [31:0] q_sat;

  assign q_big = |dq[63:31];
  assign q_neg = (dq != 64'd0) && (tn != nq[32]);

  always_comb begin
    if (q_neg) begin
      q_sat = q_big ? 32'sh8000_0000 : 32'(32'd0 - dq[31:0]);
    end else begin
      q_sat = q_big ? 32'sh7FFF_FFFF : dq[31:0];
    end
  end

  // result of the item
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (act == ACT_ORDER) begin
        res_acc    <= (reason_c == REASON_NONE);
        res_reason <= reason_c;
        res_q      <= held;
        res_a      <= avg;
      end else begin
        res_acc    <= 1'b1;
        res_reason <= REASON_NONE;
        if (!slot_ok) begin
          res_q <= 32'sd0;
          res_a <= 32'sd0;
        end else if (held == 32'sd0) begin
          // flat position takes the trade as is, zero quantity too
          res_q <= qty;
          res_a <= price;
        end else if (nq == 33'sd0) begin
          res_q <= 32'sd0;
          res_a <= 32'sd0;
        end else begin
          res_q <= sat33(nq);
          res_a <= avg;
        end
      end
    end else if (cmd.fin) begin
      res_a <= q_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= res_acc;
      m_tdata <= {5'd0, res_a, res_q, res_reason};
    end
  end

  assign sts.need_wr  = (act == ACT_FILL) && slot_ok;
  assign sts.need_div = (act == ACT_FILL) && slot_ok && (held != 32'sd0) && (nq != 33'sd0);
  assign sts.div_last = (cnt == DIV_LAST_STEP);
  assign sts.clr_last = (clr_addr == AW'(DEPTH - 1));
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

FILE: rtl/order_risk_gate_with_positions.sv
// ----------------------------------------------------------------------------
// order_risk_gate_with_positions
// pre-trade order checks against limits and a per client, per instrument
// position table that fills update with a volume-weighted average price
// ----------------------------------------------------------------------------
// After reset the block clears its position table, one entry per cycle, all
// CLIENT_SLOTS*INSTRUMENT_SLOTS entries (1024 at the defaults), before it takes
// the first item. An order check and a fill that needs no averaging skip the
// divider; a fill onto a held position goes through the 64-step serial
// divider that forms the new average. The next item is taken in the cycle
// after the result is loaded. One item is worked on at a time; a finished
// result sits in the output register while the next item is taken in.
module order_risk_gate_with_positions
  import org_pkg::*;
#(
  parameter int CLIENT_SLOTS     = 16,
  parameter int INSTRUMENT_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // client_slot[3:0], instrument_slot[9:4], trade_quantity[41:10],
  // trade_price[73:42], zero fill above
  input  logic [IN_DW-1:0]  s_tdata,
  // action
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // reject_reason[2:0], held_quantity[34:3], held_average_price[66:35],
  // zero fill above
  output logic [OUT_DW-1:0] m_tdata,
  // accepted
  output logic              m_tuser,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  org_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  org_dpath #(
    .CLIENT_SLOTS     (CLIENT_SLOTS),
    .INSTRUMENT_SLOTS (INSTRUMENT_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: tb/order_risk_gate_with_positions_test.sv
// ----------------------------------------------------------------------------
// order_risk_gate_with_positions_test
// self-checking bench for the order risk gate: a table of directed orders and
// fills, then random traffic over a few hot positions under changing limits,
// with each result checked against its row's verdict or a model of the table
// ----------------------------------------------------------------------------
module order_risk_gate_with_positions_test;
  import org_pkg::*;

  localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] QMIN = 32'h8000_0000;
  localparam logic [CFG_W-1:0] LIM62_MAX = {CFG_W{1'b1}};
  localparam logic [CFG_W-1:0] LIM31_MAX = 62'h7FFF_FFFF;

  typedef struct packed {
    logic        acc;
    logic [2:0]  rsn;
    logic [31:0] hq;
    logic [31:0] ha;
  } verdict_t;

  typedef struct packed {
    logic [1:0]  ph;
    logic        act;
    logic [3:0]  cs;
    logic [5:0]  is;
    logic [31:0] qty;
    logic [31:0] price;
    logic        typed;
    verdict_t    want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic              m_tuser;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  order_risk_gate_with_positions i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the limits and the position table
  logic [63:0]        lim_value, lim_qty, lim_pos;
  logic signed [31:0] book_qty [1024];
  logic signed [31:0] book_avg [1024];

  verdict_t verdict_q [$];
  int       fails = 0;
  int       n_seen = 0;
  int       n_fills = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  logic     stall_ask = 1'b0;

  row_t dir_rows [20] = '{
    // limits at reset: every order fails a test
    '{2'd0, ACT_ORDER, 4'd0, 6'd0, 32'd1, 32'd0, 1'b1, '{1'b0, REASON_BAD, 32'd0, 32'd0}},
    '{2'd0, ACT_ORDER, 4'd0, 6'd0, 32'd0, 32'd1, 1'b1, '{1'b0, REASON_BAD, 32'd0, 32'd0}},
    '{2'd0, ACT_ORDER, 4'd0, 6'd0, QMIN, QMAX, 1'b1, '{1'b0, REASON_BAD, 32'd0, 32'd0}},
    '{2'd0, ACT_ORDER, 4'd0, 6'd0, QMAX, QMIN, 1'b1, '{1'b0, REASON_BAD, 32'd0, 32'd0}},
    '{2'd0, ACT_ORDER, 4'd0, 6'd0, 32'd1, 32'd1, 1'b1, '{1'b0, REASON_VALUE, 32'd0, 32'd0}},
    '{2'd0, ACT_ORDER, 4'd0, 6'd0, QMAX, QMAX, 1'b1,
      '{1'b0, REASON_VALUE, 32'd0, 32'd0}},
    // fill onto a flat position takes the trade as is, zero quantity too
    '{2'd0, ACT_FILL, 4'd1, 6'd1, 32'd0, 32'd5, 1'b1, '{1'b1, REASON_NONE, 32'd0, 32'd5}},
    '{2'd0, ACT_FILL, 4'd2, 6'd2, QMAX, QMAX, 1'b1, '{1'b1, REASON_NONE, QMAX, QMAX}},
    // limits wide open
    '{2'd1, ACT_ORDER, 4'd2, 6'd2, 32'd1, 32'd1, 1'b0, '0},
    '{2'd1, ACT_FILL, 4'd1, 6'd1, 32'd7, 32'd9, 1'b0, '0},
    '{2'd1, ACT_FILL, 4'd2, 6'd2, QMAX, QMAX, 1'b0, '0},
    '{2'd1, ACT_FILL, 4'd2, 6'd2, QMIN, QMIN, 1'b0, '0},
    '{2'd1, ACT_FILL, 4'd3, 6'd3, 32'd10, 32'd100, 1'b0, '0},
    '{2'd1, ACT_FILL, 4'd3, 6'd3, -32'sd10, 32'd7, 1'b0, '0},
    '{2'd1, ACT_FILL, 4'd3, 6'd3, -32'sd5, 32'd200, 1'b0, '0},
    '{2'd1, ACT_FILL, 4'd15, 6'd63, QMIN, QMAX, 1'b0, '0},
    '{2'd1, ACT_FILL, 4'd15, 6'd63, -32'sd1, QMIN, 1'b0, '0},
    '{2'd1, ACT_ORDER, 4'd15, 6'd63, QMAX, 32'd1, 1'b0, '0},
    // tight quantity and position limits
    '{2'd2, ACT_ORDER, 4'd3, 6'd3, 32'd200, 32'd1, 1'b0, '0},
    '{2'd2, ACT_ORDER, 4'd3, 6'd3, 32'd1, 32'd1, 1'b0, '0}
  };

  function automatic logic [31:0] clamp_sm(input logic neg, input logic [64:0] m);
    if (neg) begin
      clamp_sm = (m >= 65'h8000_0000) ? QMIN : 32'(65'd0 - m);
    end else begin
      clamp_sm = (m > 65'h7FFF_FFFF) ? QMAX : m[31:0];
    end
  endfunction

  task automatic gate_and_book(input logic act, input logic [3:0] cs, input logic [5:0] is,
                               input logic [31:0] qty_in, input logic [31:0] price_in,
                               output verdict_t v);
    logic [9:0]         slot;
    longint             held, avg, qty, price, nq, p1, p2;
    logic signed [64:0] total;
    logic [64:0]        tmag, qm;
    logic [63:0]        prod, pv;
    slot  = {cs, is};
    held  = longint'(book_qty[slot]);
    avg   = longint'(book_avg[slot]);
    qty   = longint'($signed(qty_in));
    price = longint'($signed(price_in));
    v     = '{1'b1, REASON_NONE, book_qty[slot], book_avg[slot]};
    if (act == ACT_ORDER) begin
      nq   = held + qty;
      prod = 64'(price) * 64'(qty);
      pv   = 64'(nq < 0 ? -nq : nq) * 64'(avg < 0 ? -avg : avg);
      if (price <= 0 || qty <= 0) v.rsn = REASON_BAD;
      else if (prod > lim_value) v.rsn = REASON_VALUE;
      else if (64'(qty) > lim_qty) v.rsn = REASON_QUANTITY;
      else if (pv > lim_pos) v.rsn = REASON_POSITION;
      if (v.rsn != REASON_NONE) v.acc = 1'b0;
    end else begin
      if (held == 0) begin
        v.hq = qty_in;
        v.ha = price_in;
      end else begin
        p1    = held * avg;
        p2    = qty * price;
        nq    = held + qty;
        total = p1;
        total = total + 65'(signed'(p2));
        if (nq == 0) begin
          v.hq = '0;
          v.ha = '0;
        end else begin
          tmag = total < 0 ? 65'(-total) : 65'(total);
          qm   = tmag / 65'(nq < 0 ? -nq : nq);
          v.ha = clamp_sm(qm != 0 && ((total < 0) != (nq < 0)), qm);
          v.hq = clamp_sm(nq < 0, 65'(nq < 0 ? -nq : nq));
        end
      end
      book_qty[slot] = v.hq;
      book_avg[slot] = v.ha;
    end
  endtask

  task automatic offer(input logic act, input logic [3:0] cs, input logic [5:0] is,
                       input logic [31:0] qty, input logic [31:0] price,
                       input logic typed, input verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {6'b0, price, qty, is, cs};
    do @(posedge clk); while (!s_tready);
    gate_and_book(act, cs, is, qty, price, v);
    verdict_q = {verdict_q, (typed ? want : v)};
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] val, input logic [CFG_W-1:0] qty,
                            input logic [CFG_W-1:0] pos);
    cfg_we <= 1'b1; cfg_index <= CFG_MAX_ORDER_VALUE; cfg_data <= val;
    @(posedge clk);
    cfg_index <= CFG_MAX_ORDER_QUANTITY; cfg_data <= qty;
    @(posedge clk);
    cfg_index <= CFG_MAX_POSITION_VALUE; cfg_data <= pos;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_value = 64'(val);
    lim_qty   = 64'(qty[30:0]);
    lim_pos   = 64'(pos);
  endtask

  function automatic logic [31:0] pick_qty();
    case ($urandom_range(9))
      0: pick_qty = $urandom;
      1: begin
        case ($urandom_range(4))
          0: pick_qty = QMAX;
          1: pick_qty = QMIN;
          2: pick_qty = 32'd0;
          3: pick_qty = 32'd1;
          default: pick_qty = 32'hFFFF_FFFF;
        endcase
      end
      default: pick_qty = 32'($urandom_range(2000)) - 32'd1000;
    endcase
  endfunction

  function automatic logic [31:0] pick_price();
    case ($urandom_range(9))
      0: pick_price = $urandom;
      1: pick_price = $urandom_range(1) ? QMAX : QMIN;
      2: pick_price = 32'd0 - 32'($urandom_range(1000));
      default: pick_price = 32'($urandom_range(2_000_000, 1));
    endcase
  endfunction

  // result side: ready pattern, one long hold-off on request, and the check
  int   stall_left = 0;
  logic stall_taken = 1'b0;
  always @(posedge clk) begin
    verdict_t w;
    if (m_tvalid && m_tready) begin
      n_seen++;
      if (verdict_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fails++;
      end else begin
        w = verdict_q.pop_front();
        if (m_tuser !== w.acc) begin
          $error("accepted: expected %0d, got %0d", w.acc, m_tuser); fails++;
        end
        if (m_tdata[2:0] !== w.rsn) begin
          $error("reject_reason: expected %0d, got %0d", w.rsn, m_tdata[2:0]); fails++;
        end
        if (m_tdata[34:3] !== w.hq) begin
          $error("held_quantity: expected %0d, got %0d", $signed(w.hq),
                 $signed(m_tdata[34:3])); fails++;
        end
        if (m_tdata[66:35] !== w.ha) begin
          $error("held_average_price: expected %0d, got %0d", $signed(w.ha),
                 $signed(m_tdata[66:35])); fails++;
        end
      end
    end
    if (stall_ask && !stall_taken) begin
      stall_taken = 1'b1;
      stall_left  = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    logic        act;
    logic [3:0]  cs;
    logic [5:0]  is;
    logic [31:0] qty, price;
    for (int k = 0; k < 1024; k++) begin
      book_qty[k] = '0;
      book_avg[k] = '0;
    end
    lim_value = '0; lim_qty = '0; lim_pos = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle = 24; recv_idle = 50;
    for (int r = 0; r < 20; r++) begin
      if (r > 0 && dir_rows[r].ph != dir_rows[r-1].ph) begin
        drain();
        if (dir_rows[r].ph == 2'd1) set_limits(LIM62_MAX, LIM31_MAX, LIM62_MAX);
        else set_limits(LIM62_MAX, 62'd100, 62'd0);
      end
      offer(dir_rows[r].act, dir_rows[r].cs, dir_rows[r].is, dir_rows[r].qty,
            dir_rows[r].price, dir_rows[r].typed, dir_rows[r].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph < 3) begin
        send_idle = 24; recv_idle = 50;
      end else if (ph < 6) begin
        send_idle = 50; recv_idle = 24;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      case (ph)
        1: set_limits(62'({$urandom, $urandom}), 62'($urandom),
                      62'({$urandom, $urandom}));
        2, 7: set_limits(LIM62_MAX, LIM31_MAX, LIM62_MAX);
        4: set_limits('0, '0, '0);
        default: set_limits(62'($urandom_range(2_000_000_000)), 62'($urandom_range(1200)),
                            {22'd0, 8'($urandom_range(255)), 32'($urandom)});
      endcase
      for (int n = 0; n < 50; n++) begin
        if (ph == 3 && n == 5) stall_ask <= 1'b1;
        act = 1'($urandom_range(1));
        if ($urandom_range(3) != 0) begin
          cs = 4'($urandom_range(1));
          is = 6'($urandom_range(3));
        end else begin
          cs = 4'($urandom);
          is = 6'($urandom);
        end
        qty   = pick_qty();
        price = pick_price();
        if (act == ACT_FILL) n_fills++;
        offer(act, cs, is, qty, price, 1'b0, '0);
      end
    end
    drain();

    $display("checked %0d results over 20 directed and 400 random items (%0d random fills)",
             n_seen, n_fills);
    $display("limits went through reset, open, tight and random settings under three idle mixes");
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", verdict_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/org_pkg.sv
rtl/org_ram.sv
rtl/org_ctrl.sv
rtl/org_dpath.sv
rtl/order_risk_gate_with_positions.sv
tb/order_risk_gate_with_positions_test.sv
